@@ hdl/uv7_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UUIDv7 generator package
// Shared widths, register indexes, constants and control types.
// ----------------------------------------------------------------------------
package uv7_pkg;

  localparam int WORD_W    = 64;
  localparam int TS_W      = 48;
  localparam int CFG_IDX_W = 8;
  localparam int RAND_HI_W = 12;
  localparam int RAND_LO_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_SEED0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED3 = 8'd3;

  localparam logic [WORD_W-1:0] SEED0_RST = 64'd1;
  localparam logic [WORD_W-1:0] SEED1_RST = 64'd0;
  localparam logic [WORD_W-1:0] SEED2_RST = 64'd0;
  localparam logic [WORD_W-1:0] SEED3_RST = 64'd0;

  localparam logic [3:0] UUID_VERSION = 4'h7;
  localparam logic [1:0] UUID_VARIANT = 2'b10;

  localparam int ROT_RES = 7;
  localparam int ROT_S3  = 45;
  localparam int SHL_T   = 17;

  typedef struct packed {
    logic draw1;
    logic draw2;
    logic fin1;
    logic load;
  } uv7_cmd_t;

  typedef struct packed {
    logic out_free;
  } uv7_stat_t;

  function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int amt);
    return (v << amt) | (v >> (WORD_W - amt));
  endfunction

  function automatic logic [WORD_W-1:0] mul5(input logic [WORD_W-1:0] v);
    return (v << 2) + v;
  endfunction

  function automatic logic [WORD_W-1:0] mul9(input logic [WORD_W-1:0] v);
    return (v << 3) + v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/uv7_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UUIDv7 channel interfaces
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface uv7_req_if;
  import uv7_pkg::*;
  logic            valid;
  logic            ready;
  logic [TS_W-1:0] timestamp_ms;
  modport source (output valid, output timestamp_ms, input ready);
  modport sink   (input valid, input timestamp_ms, output ready);
endinterface

interface uv7_rsp_if;
  import uv7_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] uuid_upper;
  logic [WORD_W-1:0] uuid_lower;
  modport source (output valid, output uuid_upper, output uuid_lower, input ready);
  modport sink   (input valid, input uuid_upper, input uuid_lower, output ready);
endinterface

interface uv7_cfg_if;
  import uv7_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ hdl/uv7_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UUIDv7 controller
// Sequences two generator draws and the result finish steps per request.
// ----------------------------------------------------------------------------
module uv7_ctrl import uv7_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      req_valid_i,
  output logic           req_ready_o,
  input  wire uv7_stat_t stat_i,
  output uv7_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAW2,
    S_FIN1,
    S_FIN2
  } state_e;

  state_e state_q, state_d;
  logic   fire;

  assign req_ready_o = (state_q == S_IDLE) || ((state_q == S_FIN2) && stat_i.out_free);
  assign fire        = req_valid_i && req_ready_o;

  always_comb begin
    cmd_o       = '0;
    cmd_o.draw1 = fire;
    cmd_o.draw2 = (state_q == S_DRAW2);
    cmd_o.fin1  = (state_q == S_FIN1);
    cmd_o.load  = (state_q == S_FIN2) && stat_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (fire) state_d = S_DRAW2;
      end
      S_DRAW2: state_d = S_FIN1;
      S_FIN1:  state_d = S_FIN2;
      S_FIN2: begin
        if (stat_i.out_free) state_d = fire ? S_DRAW2 : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

@@ hdl/uv7_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UUIDv7 datapath
// Seed registers, xoshiro256** state, output scrambler and result register.
// ----------------------------------------------------------------------------
module uv7_datapath import uv7_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire uv7_cmd_t             cmd_i,
  output uv7_stat_t                 stat_o,
  input  wire logic [TS_W-1:0]      timestamp_ms_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,
  input  wire logic                 rsp_ready_i,
  output logic                      rsp_valid_o,
  output logic [WORD_W-1:0]         uuid_upper_o,
  output logic [WORD_W-1:0]         uuid_lower_o
);

  logic [WORD_W-1:0] seed_q [4];
  logic [WORD_W-1:0] g_q    [4];
  logic [WORD_W-1:0] g_d    [4];
  logic [WORD_W-1:0] w      [4];
  logic [WORD_W-1:0] n2, n3, t;
  logic [WORD_W-1:0] p_q, m_q, r1_q, r2;
  logic [TS_W-1:0]   ts_q;
  logic              out_valid_q;
  logic [WORD_W-1:0] upper_q, lower_q;
  logic              draw;

  assign draw = cmd_i.draw1 || cmd_i.draw2;

  // one xoshiro256** step, reseeding when word 0 is zero
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      w[i] = (g_q[0] == '0) ? seed_q[i] : g_q[i];
    end
    t      = w[1] << SHL_T;
    n2     = w[2] ^ w[0];
    n3     = w[3] ^ w[1];
    g_d[0] = w[0] ^ n3;
    g_d[1] = w[1] ^ n2;
    g_d[2] = n2 ^ t;
    g_d[3] = rotl(n3, ROT_S3);
  end

  assign r2 = mul9(rotl(m_q, ROT_RES));

  assign stat_o.out_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q[0] <= SEED0_RST;
      seed_q[1] <= SEED1_RST;
      seed_q[2] <= SEED2_RST;
      seed_q[3] <= SEED3_RST;
      for (int i = 0; i < 4; i++) g_q[i] <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SEED0: seed_q[0] <= cfg_data_i;
          REG_SEED1: seed_q[1] <= cfg_data_i;
          REG_SEED2: seed_q[2] <= cfg_data_i;
          REG_SEED3: seed_q[3] <= cfg_data_i;
          default: ;
        endcase
      end
      if (draw) begin
        for (int i = 0; i < 4; i++) g_q[i] <= g_d[i];
      end
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw1) ts_q <= timestamp_ms_i;
    if (draw) p_q <= w[1];
    if (cmd_i.draw2 || cmd_i.fin1) m_q <= mul5(p_q);
    if (cmd_i.fin1) r1_q <= mul9(rotl(m_q, ROT_RES));
    if (cmd_i.load) begin
      upper_q <= {ts_q, UUID_VERSION, r1_q[WORD_W-1 -: RAND_HI_W]};
      lower_q <= {UUID_VARIANT, r1_q[WORD_W-RAND_HI_W-1:0], r2[WORD_W-1 -: RAND_LO_W]};
    end
  end

  assign rsp_valid_o  = out_valid_q;
  assign uuid_upper_o = upper_q;
  assign uuid_lower_o = lower_q;

endmodule
`default_nettype wire

@@ hdl/uuid_v7_generator_xoshiro.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UUIDv7 generator with xoshiro256** source
// Response valid follows the request beat once the second draw, the finish
// steps and the result load are done. Two generator steps per request; a new
// request is taken only in idle or with the load, and stalls on a held response.
// Reset: generator state cleared, seeds at 1/0/0/0, first draw reseeds.
// ----------------------------------------------------------------------------
module uuid_v7_generator_xoshiro import uv7_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  uv7_req_if.sink   req_i,
  uv7_rsp_if.source rsp_o,
  uv7_cfg_if.sink   cfg_i
);

  uv7_cmd_t  cmd;
  uv7_stat_t stat;
  logic      req_ready;

  assign req_i.ready = req_ready;
  assign cfg_i.ready = 1'b1;

  uv7_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  uv7_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .timestamp_ms_i (req_i.timestamp_ms),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_valid_o    (rsp_o.valid),
    .uuid_upper_o   (rsp_o.uuid_upper),
    .uuid_lower_o   (rsp_o.uuid_lower)
  );

  a_accept_then_draw2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_ready) |=> cmd.draw2)
    else $error("second draw did not follow accepted beat");

  a_draw2_then_fin1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.draw2 |=> (cmd.fin1 && !cmd.draw1))
    else $error("finish step did not follow second draw");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result loaded over a held response");

  a_load_then_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> rsp_o.valid)
    else $error("response not valid after load");

endmodule
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UUIDv7 generator testbench
// Sends timestamp requests and seed register writes, with random idle bursts
// on the request and response sides. A local xoshiro256** model predicts
// every UUID, and each response beat is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;
  import uv7_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [WORD_W-1:0] upper;
    logic [WORD_W-1:0] lower;
  } uuid_pair_t;

  class uuid_tracker;
    logic [WORD_W-1:0] seed_word [4];
    logic [WORD_W-1:0] gen_word [4];
    uuid_pair_t        owed_uuids [$];
    int unsigned       mismatches;

    function new();
      seed_word[0] = SEED0_RST;
      seed_word[1] = SEED1_RST;
      seed_word[2] = SEED2_RST;
      seed_word[3] = SEED3_RST;
      foreach (gen_word[i]) gen_word[i] = '0;
      mismatches = 0;
    endfunction

    function void write_seed(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
      case (idx)
        REG_SEED0: seed_word[0] = val;
        REG_SEED1: seed_word[1] = val;
        REG_SEED2: seed_word[2] = val;
        REG_SEED3: seed_word[3] = val;
        default: ;
      endcase
    endfunction

    function logic [WORD_W-1:0] spin(input logic [WORD_W-1:0] v, input int n);
      return (v << n) | (v >> (WORD_W - n));
    endfunction

    // one generator step; reloads from the seeds when word 0 is zero
    function logic [WORD_W-1:0] next_draw();
      logic [WORD_W-1:0] res;
      logic [WORD_W-1:0] t;
      if (gen_word[0] == '0) begin
        foreach (gen_word[i]) gen_word[i] = seed_word[i];
      end
      res = spin(gen_word[1] * 64'd5, ROT_RES) * 64'd9;
      t = gen_word[1] << SHL_T;
      gen_word[2] = gen_word[2] ^ gen_word[0];
      gen_word[3] = gen_word[3] ^ gen_word[1];
      gen_word[1] = gen_word[1] ^ gen_word[2];
      gen_word[0] = gen_word[0] ^ gen_word[3];
      gen_word[2] = gen_word[2] ^ t;
      gen_word[3] = spin(gen_word[3], ROT_S3);
      return res;
    endfunction

    function void take_stamp(input logic [TS_W-1:0] ts);
      logic [WORD_W-1:0] r1;
      logic [WORD_W-1:0] r2;
      uuid_pair_t        want;
      r1 = next_draw();
      r2 = next_draw();
      want.upper = {ts, UUID_VERSION, r1[63:52]};
      want.lower = {UUID_VARIANT, r1[51:0], r2[63:54]};
      owed_uuids.push_back(want);
    endfunction

    function void match_uuid(input logic [WORD_W-1:0] up, input logic [WORD_W-1:0] lo);
      uuid_pair_t want;
      if (owed_uuids.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected uuid beat: upper %h lower %h", up, lo);
        return;
      end
      want = owed_uuids.pop_front();
      if (up !== want.upper || lo !== want.lower) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("uuid mismatch: upper exp %h got %h, lower exp %h got %h",
                   want.upper, up, want.lower, lo);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  bit          req_idle_on;
  bit          rsp_stall_on;
  int unsigned cycle_count = 0;
  uuid_tracker tracker;

  uv7_req_if req_bus ();
  uv7_rsp_if rsp_bus ();
  uv7_cfg_if cfg_bus ();

  uuid_v7_generator_xoshiro i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus),
    .cfg_i  (cfg_bus)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL uuid_v7_generator_xoshiro");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_bus.valid && rsp_bus.ready)
      tracker.match_uuid(rsp_bus.uuid_upper, rsp_bus.uuid_lower);
  end

  // response back-pressure in random bursts
  initial begin
    int hold = 0;
    bit was_low = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0 && !was_low && rsp_stall_on && $urandom_range(0, 3) == 0)
        hold = $urandom_range(1, 3);
      if (hold != 0) begin
        rsp_bus.ready <= 1'b0;
        hold--;
        was_low = 1'b1;
      end else begin
        rsp_bus.ready <= 1'b1;
        was_low = 1'b0;
      end
    end
  end

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [TS_W-1:0] rand_stamp();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {16'($urandom()), $urandom()};
    endcase
  endfunction

  task automatic send_stamp(input logic [TS_W-1:0] ts);
    if (req_idle_on && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.timestamp_ms <= ts;
    do @(posedge clk_i); while (!req_bus.ready);
    tracker.take_stamp(ts);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i); while (!cfg_bus.ready);
    tracker.write_seed(idx, val);
  endtask

  // all four seeds plus one write to an unmapped index
  task automatic load_seeds(input logic [WORD_W-1:0] s0, input logic [WORD_W-1:0] s1,
                            input logic [WORD_W-1:0] s2, input logic [WORD_W-1:0] s3);
    write_reg(REG_SEED0, s0);
    write_reg(REG_SEED1, s1);
    write_reg(REG_SEED2, s2);
    write_reg(REG_SEED3, s3);
    write_reg(CFG_IDX_W'($urandom_range(REG_SEED3 + 1, 255)), rand_word());
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic settle();
    req_bus.valid <= 1'b0;
    while (tracker.owed_uuids.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [WORD_W-1:0] s0;
    logic [WORD_W-1:0] s1;
    tracker = new();
    req_idle_on  = 1'b1;
    rsp_stall_on = 1'b1;
    rst_ni               <= 1'b0;
    req_bus.valid        <= 1'b0;
    req_bus.timestamp_ms <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // seed 3 = seed 0 ^ seed 1 zeroes word 0 after each step: every draw reseeds
    s1 = rand_word();
    write_reg(REG_SEED1, s1);
    write_reg(REG_SEED3, s1 ^ SEED0_RST);
    write_reg(8'hFF, '1);
    cfg_bus.valid <= 1'b0;
    send_stamp('0);
    send_stamp('1);
    send_stamp(48'hAAAA_AAAA_AAAA);
    send_stamp(48'h5555_5555_5555);
    send_stamp(48'h8000_0000_0001);
    settle();

    // seed 0 zero
    s1 = rand_word();
    load_seeds('0, s1, '0, s1);
    send_stamp(48'h0000_0000_0001);
    send_stamp(48'h7FFF_FFFF_FFFF);
    send_stamp(rand_stamp());
    send_stamp(rand_stamp());
    settle();

    // seeds 0 to 2 all ones, seed 3 zero
    load_seeds('1, '1, '1, '0);
    send_stamp('1);
    send_stamp('0);
    send_stamp(rand_stamp());
    send_stamp(rand_stamp());
    settle();

    repeat (6) begin
      s0 = ($urandom_range(0, 2) == 0) ? '0 : rand_word();
      s1 = rand_word();
      load_seeds(s0, s1, rand_word(), s0 ^ s1);
      repeat (20) send_stamp(rand_stamp());
      settle();
    end

    // free-running generator from here on
    load_seeds(rand_word() | 64'd1, rand_word(), rand_word(), rand_word());
    repeat (580) send_stamp(rand_stamp());
    req_idle_on  = 1'b0;
    rsp_stall_on = 1'b0;
    repeat (100) send_stamp(rand_stamp());
    settle();

    if (tracker.mismatches == 0) begin
      $display("PASS uuid_v7_generator_xoshiro");
    end else begin
      $display("FAIL uuid_v7_generator_xoshiro");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/uv7_pkg.sv
hdl/uv7_if.sv
hdl/uv7_ctrl.sv
hdl/uv7_datapath.sv
hdl/uuid_v7_generator_xoshiro.sv
tb/sv/tb_top.sv
